// ===== design/mtrt_pkg.sv =====
// ----------------------------------------------------------------------------
// mtrt_pkg: shared types and constants of the memory type range table
// Field widths, command and status codes, memory type codes, the table entry
// layout and the precedence rule that merges two memory types.
// ----------------------------------------------------------------------------
package mtrt_pkg;

  localparam int ADDR_W = 52;
  localparam int SIZE_W = 53;
  localparam int TYPE_W = 4;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  // An inclusive end address can reach past the size field, since a start
  // near the top of the address space plus a full-width size needs one more
  // bit.
  localparam int LAST_W = SIZE_W + 1;

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO = 2'd2;

  localparam logic [TYPE_W-1:0] MT_UC = 4'd0;
  localparam logic [TYPE_W-1:0] MT_WT = 4'd4;
  localparam logic [TYPE_W-1:0] MT_WP = 4'd5;
  localparam logic [TYPE_W-1:0] MT_WB = 4'd6;

  // One table entry. The inclusive end address is kept instead of the length,
  // so the lookup walk needs compares only.
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LAST_W-1:0] last;
    logic [TYPE_W-1:0] mtype;
  } entry_t;

  localparam int ENTRY_W = ADDR_W + LAST_W + TYPE_W;

  // Relation of one entry to the queried span.
  typedef struct packed {
    logic overlap;
    logic contain;
    logic past_end;
  } match_t;

  typedef struct packed {
    logic              full_map;
    logic [TYPE_W-1:0] mem_type;
    logic [STAT_W-1:0] status;
  } result_t;

  // Merge entry type a into running type b.
  function automatic logic [TYPE_W-1:0] merge_type(input logic [TYPE_W-1:0] a,
                                                   input logic [TYPE_W-1:0] b);
    logic [TYPE_W-1:0] r;
    if (a == b) begin
      r = a;
    end else if (a == MT_UC || b == MT_UC) begin
      r = MT_UC;
    end else if ((a == MT_WT && b == MT_WB) || (a == MT_WB && b == MT_WT)) begin
      r = MT_WT;
    end else if (a == MT_WP || b == MT_WP) begin
      r = MT_WP;
    end else if (a == MT_WB || b != MT_WB) begin
      r = b;
    end else begin
      r = (a < b) ? a : b;
    end
    return r;
  endfunction

endpackage

// ===== design/mtrt_table.sv =====
// ----------------------------------------------------------------------------
// mtrt_table: range table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mtrt_table
  import mtrt_pkg::*;
#(
  parameter int DEPTH = 32,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/mtrt_match.sv =====
// ----------------------------------------------------------------------------
// mtrt_match: span compare and type merge unit
// Relates one table entry to the queried span and merges its memory type into
// the running type. Used once per query walk step.
// ----------------------------------------------------------------------------
module mtrt_match
  import mtrt_pkg::*;
(
  input  logic [ADDR_W-1:0] span_start,
  input  logic [LAST_W-1:0] span_last,
  input  entry_t            entry,
  input  logic              seen,
  input  logic [TYPE_W-1:0] run_type,
  output match_t            rel,
  output logic [TYPE_W-1:0] new_type
);

  logic [LAST_W-1:0] sa;
  logic [LAST_W-1:0] sb;

  assign sa = {2'b00, span_start};
  assign sb = {2'b00, entry.start};

  assign rel.overlap  = (sa <= entry.last) && (sb <= span_last);
  assign rel.contain  = (sa >= sb) && (span_last <= entry.last);
  assign rel.past_end = (span_last < sb);

  assign new_type = seen ? merge_type(entry.mtype, run_type) : entry.mtype;

endmodule

// ===== design/mtrt_seq.sv =====
// ----------------------------------------------------------------------------
// mtrt_seq: command sequencer
// Takes one command at a time, walks the table for inserts (shifting entries
// up from the top) and queries (scanning from the bottom), and holds the
// result until the output stage takes it.
// ----------------------------------------------------------------------------
module mtrt_seq
  import mtrt_pkg::*;
#(
  parameter int DEPTH = 32,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [ADDR_W-1:0] in_addr,
  input  logic [SIZE_W-1:0] in_size,
  input  logic [TYPE_W-1:0] in_type,
  input  logic [TYPE_W-1:0] default_type,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_QRY  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]        state;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  idx;
  logic [ADDR_W-1:0] qstart;
  logic [LAST_W-1:0] qlast;
  logic [TYPE_W-1:0] ntype;
  logic              seen;
  logic              res_full;
  logic [TYPE_W-1:0] res_type;
  logic [STAT_W-1:0] res_status;

  logic              accept;
  logic              size_nz;
  logic              tbl_full;
  logic              tbl_empty;
  logic [SIZE_W:0]   span_sum;
  logic [SIZE_W:0]   span_m1;
  logic [LAST_W-1:0] span_last;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  entry_t            rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  entry_t            new_entry;

  match_t            rel;
  logic [TYPE_W-1:0] merged;
  logic              shift;
  logic              last_idx;
  logic              q_stop;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign size_nz   = (in_size != '0);
  assign tbl_full  = (count == CNT_W'(DEPTH));
  assign tbl_empty = (count == '0);

  assign span_sum  = {2'b00, in_addr} + {1'b0, in_size};
  assign span_m1   = span_sum - (SIZE_W + 1)'(1);
  assign span_last = span_m1;

  assign new_entry = '{start: qstart, last: qlast, mtype: ntype};

  // Insert walk: the entry below the candidate slot moves up while its start
  // lies above the new start.
  assign shift = (rd_data.start > qstart);

  assign last_idx = ((CNT_W'(idx) + CNT_W'(1)) == count);
  assign q_stop   = (rel.overlap && !rel.contain) || rel.past_end || last_idx;

  mtrt_match u_match (
    .span_start (qstart),
    .span_last  (qlast),
    .entry      (rd_data),
    .seen       (seen),
    .run_type   (res_type),
    .rel        (rel),
    .new_type   (merged)
  );

  mtrt_table #(.DEPTH(DEPTH)) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx;
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = new_entry;
    unique case (state)
      S_IDLE: begin
        if (accept && size_nz && !tbl_empty) begin
          if (in_cmd == CMD_INSERT && !tbl_full) begin
            rd_en   = 1'b1;
            rd_addr = count[IDX_W-1:0] - 1'b1;
          end else if (in_cmd == CMD_QUERY) begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
        end
      end
      S_INS: begin
        wr_en = 1'b1;
        if (shift) begin
          wr_data = rd_data;
          if (idx != IDX_W'(1)) begin
            rd_en   = 1'b1;
            rd_addr = idx - 1'b1 - 1'b1;
          end
        end
      end
      S_PUT: begin
        wr_en = 1'b1;
      end
      S_QRY: begin
        if (!q_stop) begin
          rd_en   = 1'b1;
          rd_addr = idx + 1'b1;
        end
      end
      S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            qstart     <= in_addr;
            qlast      <= span_last;
            ntype      <= in_type;
            seen       <= 1'b0;
            res_full   <= 1'b0;
            res_type   <= MT_UC;
            res_status <= STAT_DONE;
            state      <= S_FIN;
            case (in_cmd)
              CMD_CLEAR: begin
                count <= '0;
              end
              CMD_INSERT: begin
                if (!size_nz) begin
                  res_status <= STAT_ZERO;
                end else if (tbl_full) begin
                  res_status <= STAT_FULL;
                end else if (tbl_empty) begin
                  idx   <= '0;
                  state <= S_PUT;
                end else begin
                  idx   <= count[IDX_W-1:0];
                  state <= S_INS;
                end
              end
              CMD_QUERY: begin
                res_full <= 1'b1;
                res_type <= default_type;
                if (!size_nz) begin
                  res_status <= STAT_ZERO;
                end else if (!tbl_empty) begin
                  idx   <= '0;
                  state <= S_QRY;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_INS: begin
          if (shift) begin
            idx <= idx - 1'b1;
            if (idx == IDX_W'(1)) begin
              state <= S_PUT;
            end
          end else begin
            count <= count + 1'b1;
            state <= S_FIN;
          end
        end
        S_PUT: begin
          count <= count + 1'b1;
          state <= S_FIN;
        end
        S_QRY: begin
          if (rel.overlap && rel.contain) begin
            res_type <= merged;
            seen     <= 1'b1;
          end
          if (rel.overlap && !rel.contain) begin
            res_full <= 1'b0;
          end
          if (q_stop) begin
            state <= S_FIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_FIN: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid    = (state == S_FIN);
  assign res.full_map = res_full;
  assign res.mem_type = res_type;
  assign res.status   = res_status;

endmodule

// ===== design/memory_type_range_table_core.sv =====
// ----------------------------------------------------------------------------
// memory_type_range_table_core: memory type range table with lookup
// Sorted table of address ranges with memory types; clear, insert and query.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_axis channel, one item at a time; each command
//   gives exactly one result item on the m_axis channel. The default memory
//   type is written through cfg_wr_en / cfg_wr_data; the user must do this
//   only while the block is idle, which the block itself does not enforce.
//   Clear, unused and rejected commands, and queries that need no walk, go
//   straight to the sequencer's finished state and from there into the
//   output register. An insert walks down from the top of the table, moving
//   one entry up per cycle until it finds its slot. A query scans the table
//   upward one entry per cycle through the single compare and merge unit, fed
//   by the one read port of the table memory. The next item can be taken
//   in the cycle after the result moves on, so the block takes no new
//   command while one is still in work.
//   Reset empties the table (entry count zero), sets the default type to 0 and
//   drops any pending result. The table memory itself is not cleared. A result
//   waits in the output register while m_axis_tready is low, and a second
//   finished result waits inside the sequencer, which then takes no new item.
// ----------------------------------------------------------------------------
module memory_type_range_table_core
  import mtrt_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration: default memory type.
  input  logic                  cfg_wr_en,
  input  logic [TYPE_W-1:0]     cfg_wr_data,
  // Command items.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata from bit 0: address[51:0], range_size[104:52], range_type[108:105],
  // zero fill [111:109].
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: cmd[1:0].
  input  logic [CMD_W-1:0]      s_axis_tuser,
  // Result items.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata from bit 0: full_map[0], mem_type[4:1], status[6:5], zero fill [7].
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [TYPE_W-1:0] default_type;
  logic              res_valid;
  logic              res_ready;
  result_t           res;

  // Unpacked command fields.
  logic [ADDR_W-1:0] in_addr;
  logic [SIZE_W-1:0] in_size;
  logic [TYPE_W-1:0] in_type;

  assign in_addr = s_axis_tdata[ADDR_W-1:0];
  assign in_size = s_axis_tdata[ADDR_W+SIZE_W-1:ADDR_W];
  assign in_type = s_axis_tdata[ADDR_W+SIZE_W+TYPE_W-1:ADDR_W+SIZE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      default_type <= MT_UC;
    end else if (cfg_wr_en) begin
      default_type <= cfg_wr_data;
    end
  end

  mtrt_seq #(.DEPTH(TABLE_DEPTH)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_cmd       (s_axis_tuser),
    .in_addr      (in_addr),
    .in_size      (in_size),
    .in_type      (in_type),
    .default_type (default_type),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // The output register is free when empty or when its item leaves now, so a
  // result that is waiting moves on in every cycle that the receiver takes one.
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {1'b0, res.status, res.mem_type, res.full_map};
    end
  end

endmodule

// ===== design/mtrt_checker.sv =====
// ----------------------------------------------------------------------------
// mtrt_checker: port-level checks of the range table core
// Watches the command and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module mtrt_checker
  import mtrt_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Only one command is in work at a time.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command accepted while another is in work");

  // A dropped insert reports no map and no type.
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[6:5] == STAT_FULL |-> m_axis_tdata[4:0] == 5'd0)
    else $error("dropped insert carries query fields");

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind memory_type_range_table_core mtrt_checker u_mtrt_checker (.*);

// ===== tb/sv/tb_memory_type_range_table_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_memory_type_range_table_core: self-checking bench for the range table
// Sends clear, insert, query and unused commands over the input stream and
// checks every result item against a predictor that keeps its own copy of
// the sorted range table and of the default memory type. Both sides idle
// at random, the receiver holds off long enough to back the block up, and
// the default type is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_memory_type_range_table_core;
  import mtrt_pkg::*;

  localparam int DEPTH       = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_GOAL   = 1550;

  localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
  localparam logic [TYPE_W-1:0] MT_WC      = 4'd1;

  localparam logic [63:0] ADDR_MAX = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] SPAN_MAX = 64'h0010_0000_0000_0000;
  localparam logic [63:0] SIZE_TOP = 64'h001F_FFFF_FFFF_FFFF;
  localparam logic [63:0] PAGE     = 64'h1000;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] span;
    logic [TYPE_W-1:0] rtype;
  } command_t;

  typedef struct {
    logic              full_map;
    logic [TYPE_W-1:0] mem_type;
    logic [STAT_W-1:0] status;
  } outcome_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [TYPE_W-1:0]     cfg_wr_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  memory_type_range_table_core #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Predictor copy of the table and the default type.
  logic [ADDR_W-1:0] tbl_start [DEPTH];
  logic [SIZE_W-1:0] tbl_len   [DEPTH];
  logic [TYPE_W-1:0] tbl_type  [DEPTH];
  int                tbl_count = 0;
  logic [TYPE_W-1:0] dflt_type = '0;

  command_t command_backlog[$];
  outcome_t awaited_outcomes[$];

  // Ranges the generator has inserted since its last clear, used to aim queries.
  logic [63:0] known_lo[$];
  logic [63:0] known_len[$];

  int  cmds_offered = 0;
  int  cmds_taken = 0;
  int  outcomes_taken = 0;
  int  cmds_generated = 0;
  int  mismatches = 0;
  int  cycle_count = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  outcomes_seen = 0;
  int  long_holds = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;

  // Precedence of two memory types: a is the entry's type, b the running one.
  function automatic logic [TYPE_W-1:0] combine_types(logic [TYPE_W-1:0] a,
                                                      logic [TYPE_W-1:0] b);
    if (a == b) return a;
    if (a == MT_UC || b == MT_UC) return MT_UC;
    if ({a, b} == {MT_WT, MT_WB} || {a, b} == {MT_WB, MT_WT}) return MT_WT;
    if (a == MT_WP || b == MT_WP) return MT_WP;
    if (a != MT_WB && b == MT_WB) return (a < b) ? a : b;
    return b;
  endfunction

  // Applies one command to the table copy and returns the result it gives.
  function automatic outcome_t resolve_command(command_t c);
    outcome_t    o;
    logic [63:0] q_lo, q_hi, r_lo, r_hi;
    int          slot;
    bit          seen;
    o.full_map = 1'b0;
    o.mem_type = '0;
    o.status   = STAT_DONE;
    case (c.cmd)
      CMD_CLEAR: begin
        tbl_count = 0;
      end
      CMD_INSERT: begin
        if (c.span == '0) begin
          o.status = STAT_ZERO;
        end else if (tbl_count >= DEPTH) begin
          o.status = STAT_FULL;
        end else begin
          // The table stays sorted, so every entry that starts above the new
          // range sits at the tail; slide those up by one.
          slot = tbl_count;
          for (int i = tbl_count; i > 0 && tbl_start[i-1] > c.addr; i--) begin
            tbl_start[i] = tbl_start[i-1];
            tbl_len[i]   = tbl_len[i-1];
            tbl_type[i]  = tbl_type[i-1];
            slot = i - 1;
          end
          tbl_start[slot] = c.addr;
          tbl_len[slot]   = c.span;
          tbl_type[slot]  = c.rtype;
          tbl_count++;
        end
      end
      CMD_QUERY: begin
        o.full_map = 1'b1;
        o.mem_type = dflt_type;
        if (c.span == '0) begin
          o.status = STAT_ZERO;
        end else begin
          q_lo = 64'(c.addr);
          q_hi = q_lo + 64'(c.span) - 64'd1;
          seen = 1'b0;
          for (int i = 0; i < tbl_count; i++) begin
            r_lo = 64'(tbl_start[i]);
            r_hi = r_lo + 64'(tbl_len[i]) - 64'd1;
            if (r_lo > q_hi) break;
            if (q_lo <= r_hi) begin
              if (q_lo >= r_lo && q_hi <= r_hi) begin
                o.mem_type = seen ? combine_types(tbl_type[i], o.mem_type) : tbl_type[i];
                seen = 1'b1;
              end else begin
                // A range border inside the span ends the walk.
                o.full_map = 1'b0;
                break;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  // Input side: one item from the backlog at a time, with a drawn gap after it.
  always @(negedge clk) begin : feed_commands
    command_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (cmds_taken == cmds_offered) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (command_backlog.size() > 0) begin
        nxt = command_backlog.pop_front();
        s_axis_tuser  <= nxt.cmd;
        s_axis_tdata  <= {3'b000, nxt.rtype, nxt.span, nxt.addr};
        s_axis_tvalid <= 1'b1;
        cmds_offered++;
        gap_left = tx_calm ? 0 : $urandom_range(0, 12);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output side: a drawn stall before each result, and at most twice a long
  // hold-off while commands are still queued so that the block backs up.
  always @(negedge clk) begin : drain_outcomes
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (outcomes_taken != outcomes_seen) begin
        outcomes_seen = outcomes_taken;
        stall_left = rx_calm ? 0 : $urandom_range(0, 12);
        if (long_holds < 2 && outcomes_taken >= 300 + 700 * long_holds &&
            command_backlog.size() > 20) begin
          stall_left = 200;
          long_holds++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Handshakes and register writes are sampled here; predictions and checks
  // happen in the same process so the table copy sees them in bus order.
  always @(posedge clk) begin : watch_ports
    command_t got_cmd;
    outcome_t want;
    if (!rst) begin
      if (cfg_wr_en) begin
        dflt_type = cfg_wr_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        got_cmd.cmd   = s_axis_tuser;
        got_cmd.addr  = s_axis_tdata[ADDR_W-1:0];
        got_cmd.span  = s_axis_tdata[ADDR_W+SIZE_W-1:ADDR_W];
        got_cmd.rtype = s_axis_tdata[ADDR_W+SIZE_W+TYPE_W-1:ADDR_W+SIZE_W];
        awaited_outcomes.push_back(resolve_command(got_cmd));
        cmds_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        outcomes_taken++;
        if (awaited_outcomes.size() == 0) begin
          $error("result with no command outstanding: tdata %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (m_axis_tdata[0] !== want.full_map) begin
            $error("full_map: expected %0d, got %0d", want.full_map, m_axis_tdata[0]);
            mismatches++;
          end
          if (m_axis_tdata[4:1] !== want.mem_type) begin
            $error("mem_type: expected %0d, got %0d", want.mem_type, m_axis_tdata[4:1]);
            mismatches++;
          end
          if (m_axis_tdata[6:5] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tdata[6:5]);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_memory_type_range_table_core: errors");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Span for the wide address space: mostly random bit lengths, now and then
  // a span as large as the whole address space.
  function automatic logic [63:0] wide_span();
    int          nb;
    logic [63:0] v;
    nb = $urandom_range(1, 52);
    v = rand64() & ((64'd1 << nb) - 64'd1);
    if ($urandom_range(0, 19) == 0) v = SPAN_MAX;
    if (v == 64'd0) v = 64'd1;
    return v;
  endfunction

  function automatic logic [TYPE_W-1:0] pick_type();
    case ($urandom_range(0, 9))
      0, 1:    return MT_UC;
      2:       return MT_WC;
      3, 4:    return MT_WT;
      5:       return MT_WP;
      6, 7:    return MT_WB;
      default: return TYPE_W'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic queue_command(logic [CMD_W-1:0] cmd, logic [63:0] addr,
                               logic [63:0] span, logic [TYPE_W-1:0] rtype);
    command_t c;
    c.cmd   = cmd;
    c.addr  = addr[ADDR_W-1:0];
    c.span  = span[SIZE_W-1:0];
    c.rtype = rtype;
    command_backlog.push_back(c);
    cmds_generated++;
  endtask

  // A query aimed at a known range: inside it, across its end, across its
  // start, or somewhere unrelated.
  task automatic aim_query(bit wide, logic [63:0] base);
    int          pick, k;
    logic [63:0] lo, len, off, a, s;
    pick = $urandom_range(0, 99);
    if (known_lo.size() == 0 || pick >= 70) begin
      if (wide) begin
        a = rand64() & ADDR_MAX;
        s = wide_span();
      end else begin
        a = base + 64'($urandom_range(0, 80)) * PAGE;
        s = 64'($urandom_range(1, 8)) * PAGE;
      end
      if (pick >= 92) s = 64'd0;
    end else begin
      k   = $urandom_range(0, known_lo.size() - 1);
      lo  = known_lo[k];
      len = known_len[k];
      if (pick < 40) begin
        off = rand64() % len;
        a   = lo + off;
        s   = 64'd1 + rand64() % (len - off);
      end else if (pick < 55) begin
        off = rand64() % ((len < 64'd8192) ? len : 64'd8192);
        a   = lo + len - 64'd1 - off;
        s   = off + 64'd2 + rand64() % 64'd8192;
      end else begin
        a = (lo > 64'd8192) ? lo - 64'd1 - rand64() % 64'd8192 : 64'd0;
        s = lo - a + 64'd1 + rand64() % len;
      end
    end
    if (a > ADDR_MAX) a = ADDR_MAX;
    if (s > SPAN_MAX) s = SPAN_MAX;
    queue_command(CMD_QUERY, a, s, TYPE_W'($urandom_range(0, 15)));
  endtask

  // One well-formed sequence: usually a clear, a batch of inserts (sometimes
  // more than the table holds), then queries, with some noise mixed in.
  task automatic build_scenario();
    int          n_ins, n_q;
    bit          wide;
    logic [63:0] base, lo, len;
    wide = ($urandom_range(0, 9) < 3);
    base = 64'($urandom_range(0, 32'h1FFF_FFFF)) << 23;
    if ($urandom_range(0, 9) != 0) begin
      queue_command(CMD_CLEAR, rand64() & ADDR_MAX, rand64() & SPAN_MAX,
                    TYPE_W'($urandom_range(0, 15)));
      known_lo.delete();
      known_len.delete();
    end
    n_ins = ($urandom_range(0, 6) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 10);
    for (int i = 0; i < n_ins; i++) begin
      if (wide) begin
        lo  = rand64() & ADDR_MAX;
        len = wide_span();
      end else begin
        lo  = base + 64'($urandom_range(0, 63)) * PAGE;
        len = 64'($urandom_range(1, 16)) * PAGE;
        if ($urandom_range(0, 9) == 0) lo = lo + 64'($urandom_range(1, 4095));
      end
      queue_command(CMD_INSERT, lo, len, pick_type());
      known_lo.push_back(lo);
      known_len.push_back(len);
      if ($urandom_range(0, 4) == 0) aim_query(wide, base);
    end
    n_q = $urandom_range(6, 20);
    for (int i = 0; i < n_q; i++) begin
      case ($urandom_range(0, 19))
        0: queue_command(CMD_UNUSED, rand64() & ADDR_MAX, rand64() & SPAN_MAX,
                         TYPE_W'($urandom_range(0, 15)));
        1: queue_command(CMD_INSERT, rand64() & ADDR_MAX, 64'd0, pick_type());
        default: aim_query(wide, base);
      endcase
    end
  endtask

  task automatic program_default(logic [TYPE_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Returns once every queued command has been taken and answered.
  task automatic wait_idle();
    @(negedge clk);
    while (command_backlog.size() != 0 || cmds_taken != cmds_offered ||
           awaited_outcomes.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin : run_plan
    int phase;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty table, zero sizes, the unused command, the
    // highest address and span, overlapping ranges with the same start,
    // type merging, a border inside the span, a gap, a clear, and sizes
    // above the usual span whose end needs the extra address bit.
    program_default(4'd9);
    queue_command(CMD_QUERY, 64'h0, 64'd1, MT_UC);
    queue_command(CMD_QUERY, 64'h5000, 64'd0, MT_WB);
    queue_command(CMD_INSERT, 64'h7000, 64'd0, MT_WB);
    queue_command(CMD_UNUSED, ADDR_MAX, SPAN_MAX, 4'hF);
    queue_command(CMD_INSERT, ADDR_MAX, SPAN_MAX, 4'hF);
    queue_command(CMD_INSERT, 64'h0, 64'd1, MT_UC);
    queue_command(CMD_INSERT, 64'h1000, 64'h1000, MT_WB);
    queue_command(CMD_INSERT, 64'h1000, 64'h2000, MT_WT);
    queue_command(CMD_INSERT, 64'h800, 64'h4000, MT_WC);
    queue_command(CMD_INSERT, 64'h1000, 64'h800, MT_WP);
    queue_command(CMD_QUERY, 64'h1000, 64'h800, 4'h0);
    queue_command(CMD_QUERY, 64'h1800, 64'h1000, 4'h0);
    queue_command(CMD_QUERY, 64'h0, 64'd1, 4'h0);
    queue_command(CMD_QUERY, 64'h10000, 64'h10, 4'h0);
    queue_command(CMD_QUERY, ADDR_MAX, 64'd1, 4'h0);
    queue_command(CMD_QUERY, ADDR_MAX, SPAN_MAX, 4'h0);
    queue_command(CMD_QUERY, 64'h0, SPAN_MAX, 4'h0);
    queue_command(CMD_CLEAR, 64'h0, 64'h0, 4'h0);
    queue_command(CMD_QUERY, 64'h1000, 64'h1000, 4'h0);
    queue_command(CMD_INSERT, ADDR_MAX, SIZE_TOP, MT_WT);
    queue_command(CMD_QUERY, ADDR_MAX, SPAN_MAX, 4'h0);
    queue_command(CMD_QUERY, ADDR_MAX, SIZE_TOP, 4'h0);
    queue_command(CMD_QUERY, 64'h0, SIZE_TOP, 4'h0);
    queue_command(CMD_CLEAR, 64'h0, 64'h0, 4'h0);
    wait_idle();

    // Random phases, each under its own default type and idling mode.
    phase = 0;
    while (cmds_generated < ITEM_GOAL) begin
      case (phase % 6)
        0:       program_default(4'hF);
        1:       program_default(4'h0);
        2:       program_default(MT_WB);
        3:       program_default(MT_WC);
        4:       program_default(MT_WT);
        default: program_default(TYPE_W'($urandom_range(0, 15)));
      endcase
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      repeat (3) build_scenario();
      wait_idle();
      phase++;
    end

    repeat (50) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_memory_type_range_table_core: clean");
    end else begin
      $display("tb_memory_type_range_table_core: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/mtrt_pkg.sv
design/mtrt_table.sv
design/mtrt_match.sv
design/mtrt_seq.sv
design/memory_type_range_table_core.sv
design/mtrt_checker.sv
tb/sv/tb_memory_type_range_table_core.sv
